// ----- rtl/core/afr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// afr_pkg
// shared constants, command codes and the frame close record for the
// api frame receiver with packet ring
// ----------------------------------------------------------------------------
package afr_pkg;

    // ring geometry
    localparam int SLOT_BYTES = 64;
    localparam int SLOT_COUNT = 5;

    localparam int SB_W      = $clog2(SLOT_BYTES);
    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int PKT_DEPTH = SLOT_COUNT * SLOT_BYTES;
    localparam int PKT_AW    = $clog2(PKT_DEPTH);

    // field widths
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 6;
    localparam int SIZE_W   = 17;
    localparam int LEN_W    = 16;

    localparam logic [7:0] DELIM    = 8'h7E;
    localparam logic [7:0] SUM_BASE = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_RX_BYTE = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    // what the current byte does to the open frame
    typedef struct packed {
        logic              done;
        logic              ok;
        logic              too_long;
        logic [SIZE_W-1:0] size;
    } close_t;

    // slot base address in the packet memory
    function automatic logic [PKT_AW-1:0] slot_base(input logic [SLOT_W-1:0] slot);
        logic [PKT_AW+SLOT_W-1:0] prod;
        prod = (PKT_AW+SLOT_W)'(slot) * (PKT_AW+SLOT_W)'(SLOT_BYTES);
        return prod[PKT_AW-1:0];
    endfunction

    // ring pointer increment modulo the slot count
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] res;
        if (slot == SLOT_W'(SLOT_COUNT - 1)) begin
            res = '0;
        end else begin
            res = slot + SLOT_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/afr_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// afr_ram
// generic single-port ram, write or read each cycle, registered read data
// ----------------------------------------------------------------------------
module afr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/afr_deframe.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// afr_deframe
// byte-level frame tracker: delimiter, length, data sum, checksum check,
// with the assembly buffer held in a local ram
// ----------------------------------------------------------------------------
module afr_deframe (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     byte_en,
    input  wire logic [7:0]               rx_byte,
    input  wire logic [afr_pkg::SB_W-1:0] asm_raddr,
    output logic      [7:0]               asm_rdata,
    output afr_pkg::close_t               close
);

    import afr_pkg::*;

    logic [SIZE_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [7:0]        sum_reg, sum_next;
    logic              asm_we;
    logic [SB_W-1:0]   asm_addr;
    logic              in_slot;

    assign in_slot = bytes_seen_reg < SIZE_W'(SLOT_BYTES);

    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        length_next     = length_reg;
        sum_next        = sum_reg;
        asm_we          = 1'b0;
        close           = '0;
        if (byte_en) begin
            if (bytes_seen_reg == '0) begin
                // idle: hunt for the delimiter
                if (rx_byte == DELIM) begin
                    asm_we          = 1'b1;
                    bytes_seen_next = SIZE_W'(1);
                    sum_next        = '0;
                end
            end else if (bytes_seen_reg == SIZE_W'(1)) begin
                asm_we          = 1'b1;
                length_next     = {rx_byte, 8'h00};
                bytes_seen_next = SIZE_W'(2);
            end else if (bytes_seen_reg == SIZE_W'(2)) begin
                asm_we          = 1'b1;
                length_next     = {length_reg[LEN_W-1:8], rx_byte};
                bytes_seen_next = SIZE_W'(3);
            end else if (bytes_seen_reg < SIZE_W'(length_reg) + SIZE_W'(3)) begin
                asm_we          = in_slot;
                sum_next        = sum_reg + rx_byte;
                bytes_seen_next = bytes_seen_reg + SIZE_W'(1);
            end else begin
                // checksum byte closes the frame
                asm_we          = in_slot;
                bytes_seen_next = '0;
                close.done      = 1'b1;
                close.size      = bytes_seen_reg + SIZE_W'(1);
                close.ok        = rx_byte == (SUM_BASE - sum_reg);
                close.too_long  = close.size > SIZE_W'(SLOT_BYTES);
            end
        end
    end

    assign asm_addr = asm_we ? bytes_seen_reg[SB_W-1:0] : asm_raddr;

    afr_ram #(
        .WIDTH(8),
        .DEPTH(SLOT_BYTES)
    ) u_asm_ram (
        .clk  (aclk),
        .we   (asm_we),
        .addr (asm_addr),
        .wdata(rx_byte),
        .rdata(asm_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= '0;
            length_reg     <= '0;
            sum_reg        <= '0;
        end else begin
            bytes_seen_reg <= bytes_seen_next;
            length_reg     <= length_next;
            sum_reg        <= sum_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/api_frame_receiver_with_ring_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// api_frame_receiver_with_ring_top
// deframes api frames from serial bytes and keeps good ones in a ring of
// packet slots; commands read a byte of the oldest slot or release it
// ----------------------------------------------------------------------------
//  channel   ports              direction  contents
//  s_        valid/ready        in         command, rx_byte, line_error,
//                                          read_index
//  m_        valid/ready        out        frame_done, frame_good,
//                                          frame_too_long, ring_was_full,
//                                          frame_size, read_data,
//                                          last_frame_bad
//
//  serial byte, release and unused commands: result registered in the cycle after
//  the transaction; the next transaction can follow in the next cycle
//  read command: the data passes the packet ram read register before the result register
//  a byte that stores a frame copies the assembly buffer into its slot,
//  during which s_ready stays low
//  s_ready also needs the result register free or being drained this cycle
//  reset is synchronous; the ram contents are not cleared, unwritten slots
//  read as zero through per-slot valid bits
// ----------------------------------------------------------------------------
module api_frame_receiver_with_ring_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [afr_pkg::CMD_W-1:0]   s_command,
    input  wire logic [7:0]                  s_rx_byte,
    input  wire logic                        s_line_error,
    input  wire logic [afr_pkg::IDX_W-1:0]   s_read_index,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_frame_done,
    output logic                             m_frame_good,
    output logic                             m_frame_too_long,
    output logic                             m_ring_was_full,
    output logic      [afr_pkg::SIZE_W-1:0]  m_frame_size,
    output logic      [7:0]                  m_read_data,
    output logic                             m_last_frame_bad
);

    import afr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_COPY = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // ring bookkeeping
    logic [SLOT_W-1:0]     wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0]     rd_slot_reg, rd_slot_next;
    logic [SLOT_COUNT-1:0] slot_valid_reg, slot_valid_next;
    logic                  bad_reg, bad_next;

    // copy sequencer
    logic [SB_W:0]         cnt_reg, cnt_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [SB_W-1:0]       wr_idx_reg, wr_idx_next;
    logic [SLOT_W-1:0]     copy_slot_reg, copy_slot_next;
    logic                  read_ok_reg, read_ok_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    logic                  done_reg, done_next;
    logic                  good_reg, good_next;
    logic                  too_long_reg, too_long_next;
    logic                  full_reg, full_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [7:0]            rdata_reg, rdata_next;

    logic                  accept;
    logic                  byte_en;
    cmd_t                  cmd;
    close_t                close;
    logic [7:0]            asm_rdata;

    logic                  pkt_we;
    logic [PKT_AW-1:0]     pkt_addr;
    logic [PKT_AW-1:0]     pkt_raddr;
    logic [PKT_AW-1:0]     pkt_waddr;
    logic [7:0]            pkt_rdata;
    logic                  idx_in_slot;
    logic [SLOT_W-1:0]     wr_slot_inc;

    assign cmd     = cmd_t'(s_command);
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign byte_en = accept && (cmd == CMD_RX_BYTE) && !s_line_error;

    assign idx_in_slot = 32'(s_read_index) < 32'(SLOT_BYTES);
    assign wr_slot_inc = slot_inc(wr_slot_reg);

    // byte tracker and assembly buffer
    afr_deframe u_deframe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .byte_en  (byte_en),
        .rx_byte  (s_rx_byte),
        .asm_raddr(cnt_reg[SB_W-1:0]),
        .asm_rdata(asm_rdata),
        .close    (close)
    );

    // packet memory: copy writes and command reads never overlap
    assign pkt_raddr = slot_base(rd_slot_reg) + PKT_AW'(s_read_index);
    assign pkt_waddr = slot_base(copy_slot_reg) + PKT_AW'(wr_idx_reg);
    assign pkt_we    = (state_reg == ST_COPY) && wr_pend_reg;
    assign pkt_addr  = pkt_we ? pkt_waddr : pkt_raddr;

    afr_ram #(
        .WIDTH(8),
        .DEPTH(PKT_DEPTH)
    ) u_pkt_ram (
        .clk  (aclk),
        .we   (pkt_we),
        .addr (pkt_addr),
        .wdata(asm_rdata),
        .rdata(pkt_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        wr_slot_next    = wr_slot_reg;
        rd_slot_next    = rd_slot_reg;
        slot_valid_next = slot_valid_reg;
        bad_next        = bad_reg;
        cnt_next        = cnt_reg;
        wr_pend_next    = wr_pend_reg;
        wr_idx_next     = wr_idx_reg;
        copy_slot_next  = copy_slot_reg;
        read_ok_next    = read_ok_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        done_next       = done_reg;
        good_next       = good_reg;
        too_long_next   = too_long_reg;
        full_next       = full_reg;
        size_next       = size_reg;
        rdata_next      = rdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // default result: nothing closed, no read data
                    m_valid_next  = 1'b1;
                    done_next     = 1'b0;
                    good_next     = 1'b0;
                    too_long_next = 1'b0;
                    full_next     = 1'b0;
                    size_next     = '0;
                    rdata_next    = '0;
                    case (cmd)
                        CMD_RX_BYTE: begin
                            if (close.done) begin
                                done_next     = 1'b1;
                                size_next     = close.size;
                                too_long_next = close.too_long;
                                bad_next      = !close.ok;
                                if (!close.too_long && close.ok) begin
                                    // store: copy assembly buffer into the write slot
                                    good_next                    = 1'b1;
                                    copy_slot_next               = wr_slot_reg;
                                    slot_valid_next[wr_slot_reg] = 1'b1;
                                    if (wr_slot_inc != rd_slot_reg) begin
                                        wr_slot_next = wr_slot_inc;
                                    end else begin
                                        full_next = 1'b1;
                                    end
                                    cnt_next     = '0;
                                    wr_pend_next = 1'b0;
                                    state_next   = ST_COPY;
                                end
                            end
                        end
                        CMD_READ: begin
                            // result follows once the ram data is back
                            m_valid_next = 1'b0;
                            read_ok_next = idx_in_slot && slot_valid_reg[rd_slot_reg];
                            state_next   = ST_READ;
                        end
                        CMD_RELEASE: begin
                            rd_slot_next = slot_inc(rd_slot_reg);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                rdata_next   = read_ok_reg ? pkt_rdata : 8'h00;
                state_next   = ST_IDLE;
            end
            ST_COPY: begin
                if (cnt_reg < (SB_W+1)'(SLOT_BYTES)) begin
                    wr_pend_next = 1'b1;
                    wr_idx_next  = cnt_reg[SB_W-1:0];
                    cnt_next     = cnt_reg + (SB_W+1)'(1);
                end else begin
                    // last byte is written this cycle
                    wr_pend_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wr_slot_reg    <= '0;
            rd_slot_reg    <= '0;
            slot_valid_reg <= '0;
            bad_reg        <= 1'b0;
            cnt_reg        <= '0;
            wr_pend_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wr_slot_reg    <= wr_slot_next;
            rd_slot_reg    <= rd_slot_next;
            slot_valid_reg <= slot_valid_next;
            bad_reg        <= bad_next;
            cnt_reg        <= cnt_next;
            wr_pend_reg    <= wr_pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        wr_idx_reg    <= wr_idx_next;
        copy_slot_reg <= copy_slot_next;
        read_ok_reg   <= read_ok_next;
        done_reg      <= done_next;
        good_reg      <= good_next;
        too_long_reg  <= too_long_next;
        full_reg      <= full_next;
        size_reg      <= size_next;
        rdata_reg     <= rdata_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_frame_done     = done_reg;
    assign m_frame_good     = good_reg;
    assign m_frame_too_long = too_long_reg;
    assign m_ring_was_full  = full_reg;
    assign m_frame_size     = size_reg;
    assign m_read_data      = rdata_reg;
    assign m_last_frame_bad = bad_reg;

endmodule
`default_nettype wire

// ----- rtl/core/afr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// afr_checker
// port-level checks on the frame receiver, bound to the top level
// ----------------------------------------------------------------------------
module afr_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic                        m_frame_done,
    input  wire logic                        m_frame_good,
    input  wire logic                        m_frame_too_long,
    input  wire logic                        m_ring_was_full,
    input  wire logic [afr_pkg::SIZE_W-1:0]  m_frame_size,
    input  wire logic [7:0]                  m_read_data
);

    // no new transaction while an undrained result sits in the output register
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("input taken while result register is full");

    // flag consistency of a result
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((!m_frame_good || m_frame_done) && (!m_frame_too_long || m_frame_done)
                     && !(m_frame_good && m_frame_too_long)
                     && (!m_ring_was_full || m_frame_good)))
        else $error("inconsistent frame flags");

    // a closed frame carries its size, other results none
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_frame_done && m_frame_size >= 17'd4)
                     || (!m_frame_done && m_frame_size == '0)))
        else $error("frame size does not match frame done");

    // a stored frame is followed by the slot copy, which blocks input
    a_copy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(s_valid && s_ready) && m_valid && m_frame_good |-> !s_ready)
        else $error("input accepted during slot copy");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_size) && $stable(m_read_data))
        else $error("result changed while stalled");

endmodule

bind api_frame_receiver_with_ring_top afr_checker u_afr_checker (.*);
`default_nettype wire
